// ===== rtl/gpnqs_pkg.sv =====
`default_nettype none

package gpnqs_pkg;

  localparam int COORD_W = 27;
  localparam int STATE_W = 8;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;

  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_NEAR_ANY = 3'd2;
  localparam logic [2:0] OP_NEAR_TL  = 3'd3;
  localparam logic [2:0] OP_NEAR_TR  = 3'd4;
  localparam logic [2:0] OP_NEAR_BR  = 3'd5;
  localparam logic [2:0] OP_NEAR_BL  = 3'd6;

  localparam logic [COORD_W-1:0] MARKER_RST  = 27'h4000000;
  localparam logic [STATE_W-1:0] STATE_EMPTY = 8'hFF;
  localparam logic [STATE_W-1:0] STATE_UNSET = 8'h00;
  localparam logic [STATE_W-1:0] STATE_VALID = 8'h01;

  typedef struct packed {
    logic [STATE_W-1:0] st;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  localparam point_t POINT_RST = '{
    st: STATE_EMPTY, oy: MARKER_RST, ox: MARKER_RST, y: '0, x: '0
  };

  typedef struct packed {
    logic [STATE_W-1:0] read_state;
    logic [COORD_W-1:0] read_offset_y;
    logic [COORD_W-1:0] read_offset_x;
    logic [COORD_W-1:0] read_y;
    logic [COORD_W-1:0] read_x;
    logic [3:0]         found_col;
    logic [3:0]         found_row;
    logic               ok;
  } res_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [COORD_W-1:0] marker;
  } scan_cfg_t;

  typedef struct packed {
    logic       busy;
    logic       found;
    logic [3:0] row;
    logic [3:0] col;
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gpnqs_mem.sv =====
`default_nettype none

module gpnqs_mem import gpnqs_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire point_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output point_t             rd_data
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpnqs_scan.sv =====
`default_nettype none

module gpnqs_scan import gpnqs_pkg::*; #(
  parameter int RW = 4,
  parameter int CW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire scan_cfg_t     cfg,
  input  wire logic          ent_v,
  input  wire point_t        ent,
  input  wire logic [RW-1:0] ent_row,
  input  wire logic [CW-1:0] ent_col,
  output scan_stat_t         stat
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic found_r;

  logic [DIFF_W-1:0] dxs_r, dys_r;
  logic [DIFF_W-1:0] adx_r, ady_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [SQ_W-1:0]   dist_r, best_r;
  logic [RW-1:0]     row1_r, row2_r, row3_r, row4_r, best_row_r;
  logic [CW-1:0]     col1_r, col2_r, col3_r, col4_r, best_col_r;

  logic [DIFF_W-1:0] dxs, dys;
  logic              x_ge, x_le, y_ge, y_le, quad_ok, eff_ok, take;

  always_comb begin
    dxs = {ent.x[COORD_W-1], ent.x} - {cfg.qx[COORD_W-1], cfg.qx};
    dys = {ent.y[COORD_W-1], ent.y} - {cfg.qy[COORD_W-1], cfg.qy};
    x_ge = !dxs[DIFF_W-1];
    y_ge = !dys[DIFF_W-1];
    x_le = dxs[DIFF_W-1] || (dxs == '0);
    y_le = dys[DIFF_W-1] || (dys == '0);
    case (cfg.op)
      OP_NEAR_TL: quad_ok = x_ge && y_ge;
      OP_NEAR_TR: quad_ok = x_le && y_ge;
      OP_NEAR_BR: quad_ok = x_le && y_le;
      OP_NEAR_BL: quad_ok = x_ge && y_le;
      default:    quad_ok = 1'b1;
    endcase
    eff_ok = (ent.ox != cfg.marker) && (ent.oy != cfg.marker) && (ent.st == STATE_VALID);
    take = v4_r && (!found_r || (dist_r < best_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= ent_v && eff_ok && quad_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (start) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  // subtract, absolute value, square, sum, compare
  always_ff @(posedge clk) begin
    dxs_r  <= dxs;
    dys_r  <= dys;
    row1_r <= ent_row;
    col1_r <= ent_col;
    adx_r  <= dxs_r[DIFF_W-1] ? (~dxs_r + 1'b1) : dxs_r;
    ady_r  <= dys_r[DIFF_W-1] ? (~dys_r + 1'b1) : dys_r;
    row2_r <= row1_r;
    col2_r <= col1_r;
    sqx_r  <= adx_r * adx_r;
    sqy_r  <= ady_r * ady_r;
    row3_r <= row2_r;
    col3_r <= col2_r;
    dist_r <= sqx_r + sqy_r;
    row4_r <= row3_r;
    col4_r <= col3_r;
    if (take) begin
      best_r     <= dist_r;
      best_row_r <= row4_r;
      best_col_r <= col4_r;
    end
  end

  assign stat.busy  = v1_r || v2_r || v3_r || v4_r;
  assign stat.found = found_r;
  assign stat.row   = found_r ? 4'(best_row_r) : 4'd0;
  assign stat.col   = found_r ? 4'(best_col_r) : 4'd0;

endmodule

`default_nettype wire

// ===== rtl/grid_point_nearest_quadrant_search_core.sv =====
// calibration point table with nearest-point search
// input channel in_*: one request per handshake; in_tuser holds the operation
// (write, read, nearest in the whole table or in one of four quadrants),
// in_tdata the index, position, offsets and state of the point
// result channel out_*: exactly one result per request, in request order
// cfg_*: writes the offset unset marker; always ready, write it while idle
// a write goes on to S_DONE, a read through S_READ; a search walks every
// entry in S_SCAN and drains in S_DRAIN; the search is bound by the single
// table read port, one entry per cycle into a shared distance/compare pipe
// in_tready is high only while no request is in work, so one request is
// handled at a time; a new request is taken while the last result waits
// after reset a clearing pass writes every table entry, one per cycle,
// with in_tready low; the marker returns to its reset value
// when the receiver stalls the result holds in the output register and the
// next result waits in S_DONE until the output slot frees up
`default_nettype none

module grid_point_nearest_quadrant_search_core import gpnqs_pkg::*; #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // row_index, col_index, pos_x, pos_y, offset_x, offset_y, point_state
  input  wire logic [135:0] in_tdata,
  // operation
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // ok, found_row, found_col, read_x, read_y, read_offset_x, read_offset_y,
  // read_state
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [26:0]  cfg_data
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [RW-1:0]      row_r, row_nxt, tag_row_r;
  logic [CW-1:0]      col_r, col_nxt, tag_col_r;
  logic               rd_v_r;
  logic [2:0]         op_r, op_nxt;
  logic [COORD_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [COORD_W-1:0] marker_r;
  res_t               res_r, res_nxt, out_r, out_nxt;
  logic               out_tvalid_r, out_v_nxt;

  logic [2:0]         in_op;
  logic [7:0]         in_row, in_col;
  point_t             in_pt;
  logic [15:0]        idx_full;
  logic               in_range;

  logic               mem_we, mem_re, scan_start;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  point_t             mem_wdata, mem_rdata;
  scan_cfg_t          scan_cfg;
  scan_stat_t         scan_stat;

  assign in_op     = in_tuser;
  assign in_row    = in_tdata[7:0];
  assign in_col    = in_tdata[15:8];
  assign in_pt.x   = in_tdata[42:16];
  assign in_pt.y   = in_tdata[69:43];
  assign in_pt.ox  = in_tdata[96:70];
  assign in_pt.oy  = in_tdata[123:97];
  assign in_pt.st  = in_tdata[131:124];

  assign idx_full  = 16'(in_row) * 16'(GRID_COLS) + 16'(in_col);
  assign in_range  = ({1'b0, in_row} < 9'(GRID_ROWS)) && ({1'b0, in_col} < 9'(GRID_COLS));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_r};
  assign cfg_ready  = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    op_nxt     = op_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    out_v_nxt  = out_tvalid_r && !out_tready;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = POINT_RST;
    mem_re     = 1'b0;
    mem_raddr  = addr_r;
    scan_start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == AW'(CELLS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt = '0;
          op_nxt  = in_op;
          qx_nxt  = in_pt.x;
          qy_nxt  = in_pt.y;
          case (in_op)
            OP_WRITE: begin
              mem_we     = in_range;
              mem_waddr  = idx_full[AW-1:0];
              mem_wdata  = in_pt;
              res_nxt.ok = in_range;
              state_nxt  = S_DONE;
            end
            OP_READ: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = idx_full[AW-1:0];
                state_nxt = S_READ;
              end else begin
                res_nxt.read_state = STATE_EMPTY;
                state_nxt          = S_DONE;
              end
            end
            OP_NEAR_ANY, OP_NEAR_TL, OP_NEAR_TR, OP_NEAR_BR, OP_NEAR_BL: begin
              addr_nxt   = '0;
              row_nxt    = '0;
              col_nxt    = '0;
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.ok            = 1'b1;
        res_nxt.read_x        = mem_rdata.x;
        res_nxt.read_y        = mem_rdata.y;
        res_nxt.read_offset_x = mem_rdata.ox;
        res_nxt.read_offset_y = mem_rdata.oy;
        res_nxt.read_state    = (mem_rdata.ox == marker_r || mem_rdata.oy == marker_r)
                                ? STATE_UNSET : mem_rdata.st;
        state_nxt             = S_DONE;
      end
      S_SCAN: begin
        mem_re = 1'b1;
        if (col_r == CW'(GRID_COLS - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !scan_stat.busy) begin
          res_nxt.ok        = scan_stat.found;
          res_nxt.found_row = scan_stat.row;
          res_nxt.found_col = scan_stat.col;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      addr_r       <= '0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      marker_r     <= MARKER_RST;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      rd_v_r       <= (state_r == S_SCAN);
      out_tvalid_r <= out_v_nxt;
      if (cfg_valid) begin
        marker_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    tag_row_r <= row_r;
    tag_col_r <= col_r;
    op_r      <= op_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign scan_cfg.op     = op_r;
  assign scan_cfg.qx     = qx_r;
  assign scan_cfg.qy     = qy_r;
  assign scan_cfg.marker = marker_r;

  gpnqs_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  gpnqs_scan #(
    .RW (RW),
    .CW (CW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .cfg     (scan_cfg),
    .ent_v   (rd_v_r),
    .ent     (mem_rdata),
    .ent_row (tag_row_r),
    .ent_col (tag_col_r),
    .stat    (scan_stat)
  );

endmodule

`default_nettype wire

// ===== rtl/gpnqs_chk.sv =====
`default_nettype none

module gpnqs_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

  // one request at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // a failed request reports no point
  a_fail_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("point reported on failure");

endmodule

bind grid_point_nearest_quadrant_search_core gpnqs_chk u_chk (.*);

`default_nettype wire

// ===== dv/gpnqs_table_checker.sv =====
`default_nettype none

module gpnqs_table_checker import gpnqs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [135:0] in_tdata,
  input  wire logic [2:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [127:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [26:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  localparam int ROWS  = 16;
  localparam int COLS  = 16;
  localparam int CELLS = ROWS * COLS;

  logic signed [COORD_W-1:0] marker;
  logic signed [COORD_W-1:0] pt_x  [CELLS];
  logic signed [COORD_W-1:0] pt_y  [CELLS];
  logic signed [COORD_W-1:0] pt_ox [CELLS];
  logic signed [COORD_W-1:0] pt_oy [CELLS];
  logic signed [STATE_W-1:0] pt_st [CELLS];
  res_t owed_answers[$];
  int errors = 0;
  int answers_seen = 0;

  function automatic logic signed [STATE_W-1:0] live_state(int i);
    if (pt_ox[i] == marker || pt_oy[i] == marker) begin
      return STATE_UNSET;
    end
    return pt_st[i];
  endfunction

  // applies one request to the point table and returns its result
  function automatic res_t predict_answer(logic [2:0] op, logic [135:0] d);
    logic [7:0] row;
    logic [7:0] col;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic hit;
    logic found;
    logic fits;
    int idx;
    int i;
    longint best;
    longint dx;
    longint dy;
    longint sq_dist;
    res_t r;
    row = d[7:0];
    col = d[15:8];
    qx = d[42:16];
    qy = d[69:43];
    hit = (row < ROWS) && (col < COLS);
    idx = hit ? row * COLS + col : 0;
    r = '0;
    found = 1'b0;
    best = 0;
    case (op)
      OP_WRITE: begin
        if (hit) begin
          pt_x[idx] = qx;
          pt_y[idx] = qy;
          pt_ox[idx] = d[96:70];
          pt_oy[idx] = d[123:97];
          pt_st[idx] = d[131:124];
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (hit) begin
          r.ok = 1'b1;
          r.read_x = pt_x[idx];
          r.read_y = pt_y[idx];
          r.read_offset_x = pt_ox[idx];
          r.read_offset_y = pt_oy[idx];
          r.read_state = live_state(idx);
        end else begin
          r.read_state = STATE_EMPTY;
        end
      end
      OP_NEAR_ANY, OP_NEAR_TL, OP_NEAR_TR, OP_NEAR_BR, OP_NEAR_BL: begin
        for (i = 0; i < CELLS; i++) begin
          if (live_state(i) == STATE_VALID) begin
            case (op)
              OP_NEAR_TL: fits = pt_x[i] >= qx && pt_y[i] >= qy;
              OP_NEAR_TR: fits = pt_x[i] <= qx && pt_y[i] >= qy;
              OP_NEAR_BR: fits = pt_x[i] <= qx && pt_y[i] <= qy;
              OP_NEAR_BL: fits = pt_x[i] >= qx && pt_y[i] <= qy;
              default:    fits = 1'b1;
            endcase
            if (fits) begin
              dx = longint'(pt_x[i]) - longint'(qx);
              dy = longint'(pt_y[i]) - longint'(qy);
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              sq_dist = dx * dx + dy * dy;
              if (!found || sq_dist < best) begin
                found = 1'b1;
                best = sq_dist;
                r.found_row = 4'(i / COLS);
                r.found_col = 4'(i % COLS);
              end
            end
          end
        end
        r.ok = found;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (errors < 40) begin
      $display("mismatch on result %0d: %s", answers_seen, msg);
    end
    errors++;
  endtask

  task automatic check_answer(res_t got, res_t want);
    if (got.ok !== want.ok)
      flag_mismatch($sformatf("ok got %0h want %0h", got.ok, want.ok));
    if (got.found_row !== want.found_row)
      flag_mismatch($sformatf("found_row got %0d want %0d", got.found_row, want.found_row));
    if (got.found_col !== want.found_col)
      flag_mismatch($sformatf("found_col got %0d want %0d", got.found_col, want.found_col));
    if (got.read_x !== want.read_x)
      flag_mismatch($sformatf("read_x got %0h want %0h", got.read_x, want.read_x));
    if (got.read_y !== want.read_y)
      flag_mismatch($sformatf("read_y got %0h want %0h", got.read_y, want.read_y));
    if (got.read_offset_x !== want.read_offset_x)
      flag_mismatch($sformatf("read_offset_x got %0h want %0h",
                              got.read_offset_x, want.read_offset_x));
    if (got.read_offset_y !== want.read_offset_y)
      flag_mismatch($sformatf("read_offset_y got %0h want %0h",
                              got.read_offset_y, want.read_offset_y));
    if (got.read_state !== want.read_state)
      flag_mismatch($sformatf("read_state got %0h want %0h", got.read_state, want.read_state));
  endtask

  always @(posedge clk) begin
    int i;
    if (!rst_n) begin
      marker = MARKER_RST;
      for (i = 0; i < CELLS; i++) begin
        pt_x[i] = '0;
        pt_y[i] = '0;
        pt_ox[i] = MARKER_RST;
        pt_oy[i] = MARKER_RST;
        pt_st[i] = STATE_EMPTY;
      end
      owed_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        marker = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        answers_seen++;
        if (owed_answers.size() == 0) begin
          flag_mismatch($sformatf("result %0h with no request waiting", out_tdata));
        end else begin
          check_answer(res_t'(out_tdata[$bits(res_t)-1:0]), owed_answers.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        owed_answers.push_back(predict_answer(in_tuser, in_tdata));
      end
    end
    pending <= owed_answers.size();
    fail_count <= errors;
  end

endmodule

`default_nettype wire

// ===== dv/grid_point_nearest_quadrant_search_core_tb.sv =====
`default_nettype none

module grid_point_nearest_quadrant_search_core_tb import gpnqs_pkg::*;;

  localparam logic [2:0] OP_NONE = 3'd7;
  localparam int LIMIT = 2_000_000;
  localparam logic [COORD_W-1:0] C_MIN = 27'h4000000;
  localparam logic [COORD_W-1:0] C_MAX = 27'h3FFFFFF;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [26:0]  cfg_data = '0;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  logic         calm = 1'b0;

  grid_point_nearest_quadrant_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  gpnqs_table_checker table_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 14);
  end

  task automatic send_request(input logic [2:0] op, input logic [7:0] row, col,
                              input logic [26:0] px, py, ox, oy, input logic [7:0] st);
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, st, oy, ox, py, px, col, row};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_marker(input logic [26:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait for every owed result to drain
  task automatic settle(input int tail);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [26:0] rand_coord();
    int m;
    m = $urandom_range(9);
    if (m < 6) return 27'($urandom_range(400)) - 27'd200;
    if (m < 8) return 27'($urandom);
    if (m == 8) return C_MIN + 27'($urandom_range(1));
    return C_MAX - 27'($urandom_range(1));
  endfunction

  task automatic send_random_request(input logic [26:0] mk);
    int pick;
    logic [2:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] st;
    logic [26:0] ox;
    logic [26:0] oy;
    pick = $urandom_range(99);
    if (pick < 36) op = OP_WRITE;
    else if (pick < 56) op = OP_READ;
    else if (pick < 97) op = OP_NEAR_ANY + 3'($urandom_range(4));
    else op = OP_NONE;
    row = ($urandom_range(99) < 88) ? 8'($urandom_range(15)) : 8'($urandom);
    col = ($urandom_range(99) < 88) ? 8'($urandom_range(15)) : 8'($urandom);
    ox = ($urandom_range(99) < 15) ? mk : rand_coord();
    oy = ($urandom_range(99) < 15) ? mk : rand_coord();
    pick = $urandom_range(99);
    if (pick < 70) st = STATE_VALID;
    else if (pick < 78) st = STATE_EMPTY;
    else if (pick < 86) st = STATE_UNSET;
    else st = 8'($urandom);
    send_request(op, row, col, rand_coord(), rand_coord(), ox, oy, st);
  endtask

  initial begin
    int phase;
    int n;
    logic [26:0] mk;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: mk = C_MIN;
        1: mk = C_MAX;
        2: mk = 27'd0;
        3: mk = 27'($urandom);
        default: mk = C_MIN;
      endcase
      if (phase != 0) settle(4);
      calm <= (phase == 2);
      write_marker(mk);
      if (phase == 0) begin
        // fresh table, then extremes, unset offsets, bad indexes, ties and quadrants
        send_request(OP_READ, 8'd0, 8'd0, '0, '0, '0, '0, '0);
        send_request(OP_NEAR_ANY, 8'd0, 8'd0, '0, '0, '0, '0, '0);
        send_request(OP_WRITE, 8'd0, 8'd0, C_MIN, C_MAX, 27'd5, 27'd6, STATE_VALID);
        send_request(OP_WRITE, 8'd15, 8'd15, C_MAX, C_MIN, C_MIN, 27'd7, STATE_VALID);
        send_request(OP_WRITE, 8'd15, 8'd14, '0, '0, 27'd9, C_MIN, STATE_VALID);
        send_request(OP_READ, 8'd15, 8'd15, '0, '0, '0, '0, '0);
        send_request(OP_READ, 8'd15, 8'd14, '0, '0, '0, '0, '0);
        send_request(OP_WRITE, 8'd16, 8'd0, 27'd1, 27'd1, 27'd1, 27'd1, STATE_VALID);
        send_request(OP_WRITE, 8'd0, 8'd16, 27'd1, 27'd1, 27'd1, 27'd1, STATE_VALID);
        send_request(OP_WRITE, 8'd255, 8'd255, C_MAX, C_MAX, C_MAX, C_MAX, STATE_EMPTY);
        send_request(OP_READ, 8'd200, 8'd3, '0, '0, '0, '0, '0);
        send_request(OP_READ, 8'd3, 8'd200, '0, '0, '0, '0, '0);
        send_request(OP_WRITE, 8'd3, 8'd4, 27'd100, 27'd100, 27'd1, 27'd1, STATE_VALID);
        send_request(OP_WRITE, 8'd5, 8'd6, 27'd100, 27'd100, 27'd2, 27'd2, STATE_VALID);
        send_request(OP_WRITE, 8'd7, 8'd7, 27'd150, 27'd40, 27'd3, 27'd3, STATE_VALID);
        send_request(OP_WRITE, 8'd1, 8'd1, 27'd200, 27'd50, 27'd4, 27'd4, 8'd2);
        send_request(OP_NEAR_ANY, 8'd0, 8'd0, 27'd100, 27'd100, '0, '0, '0);
        send_request(OP_NEAR_TL, 8'd0, 8'd0, 27'd120, 27'd90, '0, '0, '0);
        send_request(OP_NEAR_TR, 8'd0, 8'd0, 27'd120, 27'd90, '0, '0, '0);
        send_request(OP_NEAR_BR, 8'd0, 8'd0, 27'd120, 27'd90, '0, '0, '0);
        send_request(OP_NEAR_BL, 8'd0, 8'd0, 27'd120, 27'd90, '0, '0, '0);
        send_request(OP_NEAR_ANY, 8'd0, 8'd0, C_MAX, C_MIN, '0, '0, '0);
        send_request(OP_NONE, 8'hFF, 8'hFF, C_MAX, C_MAX, C_MAX, C_MAX, 8'hFF);
        send_request(OP_READ, 8'd3, 8'd4, '0, '0, '0, '0, '0);
      end
      for (n = 0; n < ((phase == 0) ? 200 : 230); n++) begin
        send_random_request(mk);
      end
    end
    settle(20);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
